[rtl/core/box_blur_3x3_rgb_core_defines.svh]
// ---------------------------------------------------------------------------
// Box blur core assertion macros
// Assertion wrappers; they compile to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGB_CORE_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_CORE_DEFINES_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define BB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication.
`define BB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define BB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BB_ASSERT(name, prop, msg)
`define BB_ASSERT_IMP(name, ante, cons, msg)
`define BB_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

[rtl/core/bb_pkg.sv]
// ---------------------------------------------------------------------------
// Box blur package
// Sizes, item structures and the rounding reciprocal tables of the blur core.
// ---------------------------------------------------------------------------
package bb_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  // The input row counter runs past the last row while the frame drains.
  localparam int ROW_W        = $clog2(MAX_HEIGHT) + 1;
  localparam int OUT_ROW_W    = $clog2(MAX_HEIGHT);
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CH_W         = 8;
  localparam int PIX_W        = 3 * CH_W;
  localparam int SUM_W        = 12;
  localparam int HALF_W       = 3;
  localparam int RECIP_W      = 16;
  localparam int RECIP_SHIFT  = 15;
  localparam int PROD_W       = SUM_W + RECIP_W;
  localparam int Q_DEPTH      = 4;
  localparam int Q_AW         = $clog2(Q_DEPTH);

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  // Configuration register indexes.
  localparam logic [0:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic emit;
    logic left_ok;
    logic right_ok;
    logic top_ok;
    logic bottom_ok;
    logic frame_end;
  } bb_ctrl_t;

  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
    logic [PIX_W-1:0] pixel;
    bb_ctrl_t         ctrl;
  } bb_entry_t;

  // Rounded mean of n values: ((sum + n/2) * recip) >> RECIP_SHIFT, with recip
  // the reciprocal of n rounded up. nr and nc are row and column counts 1..3.
  function automatic logic [RECIP_W-1:0] bb_recip(input logic [1:0] nr,
                                                  input logic [1:0] nc);
    logic [RECIP_W-1:0] r;
    case ({nr, nc})
      4'b0101:          r = 16'd32768;
      4'b0110, 4'b1001: r = 16'd16384;
      4'b0111, 4'b1101: r = 16'd10923;
      4'b1010:          r = 16'd8192;
      4'b1011, 4'b1110: r = 16'd5462;
      4'b1111:          r = 16'd3641;
      default:          r = 16'd32768;
    endcase
    return r;
  endfunction

  function automatic logic [HALF_W-1:0] bb_half(input logic [1:0] nr,
                                                input logic [1:0] nc);
    logic [HALF_W-1:0] h;
    case ({nr, nc})
      4'b0101:          h = 3'd0;
      4'b0110, 4'b1001: h = 3'd1;
      4'b0111, 4'b1101: h = 3'd1;
      4'b1010:          h = 3'd2;
      4'b1011, 4'b1110: h = 3'd3;
      4'b1111:          h = 3'd4;
      default:          h = 3'd0;
    endcase
    return h;
  endfunction

endpackage

[rtl/core/bb_front.sv]
// ---------------------------------------------------------------------------
// Box blur front end
// Accepts items, tracks the frame position, reads and updates the line
// store and pushes one column of three pixels per kept item to the queue.
// ---------------------------------------------------------------------------
module bb_front import bb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [CH_W-1:0]       in_blue,
  input  logic [CH_W-1:0]       in_green,
  input  logic [CH_W-1:0]       in_red,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  q_push,
  output bb_entry_t             q_entry,
  input  logic                  q_full,
  output logic                  win_clear
);

  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [WIDTH_REG_W-1:0]  w_m1_full;
  logic [HEIGHT_REG_W-1:0] h_m1_full;
  logic [COL_W-1:0]        w_m1;
  logic [OUT_ROW_W-1:0]    h_m1;

  logic [COL_W-1:0]     in_col_r, in_col_nxt;
  logic [ROW_W-1:0]     in_row_r, in_row_nxt;
  logic [COL_W-1:0]     out_col_r, out_col_nxt;
  logic [OUT_ROW_W-1:0] out_row_r, out_row_nxt;

  logic                 s1_valid_r;
  logic [COL_W-1:0]     s1_addr_r;
  logic [PIX_W-1:0]     s1_pix_r;
  bb_ctrl_t             s1_ctrl_r;
  logic                 fwd_r;
  logic [2*PIX_W-1:0]   fwd_data_r;
  logic [2*PIX_W-1:0]   rdata_r;
  logic [2*PIX_W-1:0]   store_mem [MAX_WIDTH];

  logic                 fire, accept, skip, take, emit;
  bb_ctrl_t             ctrl;
  logic [PIX_W-1:0]     pix;
  logic [2*PIX_W-1:0]   rd;
  logic [PIX_W-1:0]     up_px, mid_px;

  // A width or height of zero counts as one; larger values saturate.
  always_comb begin
    if (width_r == '0) begin
      w_eff = 11'd1;
    end else if (width_r > WIDTH_REG_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = 13'd1;
    end else if (height_r > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  assign w_m1_full = w_eff - 11'd1;
  assign h_m1_full = h_eff - 13'd1;
  assign w_m1      = w_m1_full[COL_W-1:0];
  assign h_m1      = h_m1_full[OUT_ROW_W-1:0];

  assign fire     = s1_valid_r && !q_full;
  assign in_stall = s1_valid_r && q_full;
  assign accept   = in_valid && !in_stall;

  // Pixels after the last row and drain items before it are dropped.
  assign skip = in_action ? (in_row_r < ROW_W'(h_eff)) : (in_row_r >= ROW_W'(h_eff));
  assign take = accept && !skip;
  assign emit = (in_row_r >= 13'd2) || ((in_row_r == 13'd1) && (in_col_r != '0));

  always_comb begin
    ctrl.emit      = emit;
    ctrl.left_ok   = (out_col_r != '0);
    ctrl.right_ok  = (out_col_r != w_m1);
    ctrl.top_ok    = (out_row_r != '0);
    ctrl.bottom_ok = (out_row_r != h_m1);
    ctrl.frame_end = emit && (out_col_r == w_m1) && (out_row_r == h_m1);
  end

  assign pix    = in_action ? '0 : {in_red, in_green, in_blue};
  assign rd     = fwd_r ? fwd_data_r : rdata_r;
  assign up_px  = rd[2*PIX_W-1:PIX_W];
  assign mid_px = rd[PIX_W-1:0];

  assign q_push          = fire;
  assign q_entry.upper   = up_px;
  assign q_entry.middle  = mid_px;
  assign q_entry.pixel   = s1_pix_r;
  assign q_entry.ctrl    = s1_ctrl_r;
  assign win_clear       = cfg_we;

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_we) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (take) begin
      if (in_col_r == w_m1) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 13'd1;
      end else begin
        in_col_nxt = in_col_r + 10'd1;
      end
      if (ctrl.frame_end) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (emit) begin
        if (out_col_r == w_m1) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 12'd1;
        end else begin
          out_col_nxt = out_col_r + 10'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_RESET;
      height_r   <= HEIGHT_RESET;
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WIDTH_REG_W-1:0];
          CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[HEIGHT_REG_W-1:0];
          default: ;
        endcase
      end
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      if (take) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Line store: each entry holds the pixels of the two rows above, upper in
  // the top half. When a read meets the write of the same entry (a frame one
  // pixel wide), the written data is forwarded.
  always_ff @(posedge clk) begin
    if (fire) begin
      store_mem[s1_addr_r] <= {mid_px, s1_pix_r};
    end
    if (take) begin
      rdata_r    <= store_mem[in_col_r];
      fwd_r      <= fire && (s1_addr_r == in_col_r);
      fwd_data_r <= {mid_px, s1_pix_r};
      s1_addr_r  <= in_col_r;
      s1_pix_r   <= pix;
      s1_ctrl_r  <= ctrl;
    end
  end

endmodule

[rtl/core/bb_queue.sv]
// ---------------------------------------------------------------------------
// Box blur column queue
// Short FIFO of column entries between the front end and the filter.
// ---------------------------------------------------------------------------
module bb_queue import bb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  bb_entry_t push_entry,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output bb_entry_t head
);

  bb_entry_t         slot_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]     count_r, count_nxt;

  assign full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign valid = (count_r != '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[rtl/core/bb_back.sv]
// ---------------------------------------------------------------------------
// Box blur filter back end
// Shifts columns into the 3x3 window, sums the neighbours that lie inside
// the frame and divides by their count with rounding, in three stages.
// ---------------------------------------------------------------------------
module bb_back import bb_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  bb_entry_t       q_head,
  output logic            q_pop,
  input  logic            win_clear,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CH_W-1:0] out_blue,
  output logic [CH_W-1:0] out_green,
  output logic [CH_W-1:0] out_red,
  output logic            out_frame_end
);

  logic [PIX_W-1:0]   win_r [3][3];
  logic               clear_pend_r;
  logic               adv;

  logic               b1_valid_r;
  bb_ctrl_t           b1_ctrl_r;

  logic               b2_valid_r;
  logic               b2_fe_r;
  logic [SUM_W-1:0]   b2_t_r [3];
  logic [RECIP_W-1:0] b2_recip_r;

  logic               out_valid_r;
  logic               out_fe_r;
  logic [CH_W-1:0]    out_ch_r [3];

  logic [2:0]         rmask, cmask;
  logic [1:0]         nr, nc;
  logic [SUM_W-1:0]   t_nxt [3];
  logic [PROD_W-1:0]  prod [3];

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = q_valid && adv;

  assign rmask = {b1_ctrl_r.bottom_ok, 1'b1, b1_ctrl_r.top_ok};
  assign cmask = {b1_ctrl_r.right_ok, 1'b1, b1_ctrl_r.left_ok};
  assign nr    = 2'd1 + {1'b0, b1_ctrl_r.top_ok} + {1'b0, b1_ctrl_r.bottom_ok};
  assign nc    = 2'd1 + {1'b0, b1_ctrl_r.left_ok} + {1'b0, b1_ctrl_r.right_ok};

  // Row sums first, then the total, plus half the count for rounding.
  always_comb begin
    logic [SUM_W-1:0] row_sum [3];
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++) begin
        row_sum[i] = '0;
        for (int j = 0; j < 3; j++) begin
          if (rmask[i] && cmask[j]) begin
            row_sum[i] = row_sum[i] + SUM_W'(win_r[i][j][ch*CH_W +: CH_W]);
          end
        end
      end
      t_nxt[ch] = row_sum[0] + row_sum[1] + row_sum[2] + SUM_W'(bb_half(nr, nc));
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PROD_W'(b2_t_r[ch]) * PROD_W'(b2_recip_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_pend_r <= 1'b0;
      b1_valid_r   <= 1'b0;
      b2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      // After the last result of a frame, or a register write, the window
      // starts again from zero.
      if (win_clear) begin
        clear_pend_r <= 1'b1;
      end else if (q_pop) begin
        clear_pend_r <= q_head.ctrl.frame_end;
      end
      if (q_pop) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i][0] <= clear_pend_r ? '0 : win_r[i][1];
          win_r[i][1] <= clear_pend_r ? '0 : win_r[i][2];
        end
        win_r[0][2] <= q_head.upper;
        win_r[1][2] <= q_head.middle;
        win_r[2][2] <= q_head.pixel;
      end
      if (adv) begin
        b1_valid_r  <= q_pop && q_head.ctrl.emit;
        b2_valid_r  <= b1_valid_r;
        out_valid_r <= b2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_ctrl_r <= q_head.ctrl;
    end
    if (adv) begin
      b2_fe_r    <= b1_ctrl_r.frame_end;
      b2_recip_r <= bb_recip(nr, nc);
      for (int ch = 0; ch < 3; ch++) begin
        b2_t_r[ch]   <= t_nxt[ch];
        out_ch_r[ch] <= prod[ch][RECIP_SHIFT +: CH_W];
      end
      out_fe_r <= b2_fe_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_blue      = out_ch_r[0];
  assign out_green     = out_ch_r[1];
  assign out_red       = out_ch_r[2];
  assign out_frame_end = out_fe_r;

endmodule

[rtl/core/box_blur_3x3_rgb_core.sv]
// ---------------------------------------------------------------------------
// Box blur 3x3 RGB core
// Streaming 3x3 box blur of RGB pixels in raster order.
// ---------------------------------------------------------------------------
// Pixels enter on the in_ channel (in_action low) in raster order; every
// output channel is the rounded mean of the neighbours inside the frame.
// Results trail the pixels by one row and one column, so after the last
// pixel of a frame the source sends image_width+1 drain items (in_action
// high) to flush them; out_frame_end marks the last result of the frame.
// Pixels arriving during the flush and drain items arriving early are taken
// and dropped without effect.
// Throughput is one item per cycle while out_ does not stall. Between an
// accepted item and the result that it completes lie the line store read,
// the column queue, then window update, neighbour sum and the rounding
// multiply in the filter.
// A stall on out_ backs up the filter pipeline, fills the four-entry queue
// and then raises in_stall; nothing is lost.
// Reset loads image_width 640 and image_height 480 and starts a new frame;
// the line store needs no clearing. A register write also restarts the frame;
// the user must make it only while the core holds no work (not enforced).
// ---------------------------------------------------------------------------
`include "box_blur_3x3_rgb_core_defines.svh"

module box_blur_3x3_rgb_core import bb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [CH_W-1:0]       in_blue,
  input  logic [CH_W-1:0]       in_green,
  input  logic [CH_W-1:0]       in_red,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CH_W-1:0]       out_blue,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_red,
  output logic                  out_frame_end,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic      q_push, q_full, q_pop, q_valid, win_clear;
  bb_entry_t q_in, q_head;

  bb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_blue   (in_blue),
    .in_green  (in_green),
    .in_red    (in_red),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_entry   (q_in),
    .q_full    (q_full),
    .win_clear (win_clear)
  );

  bb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  bb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .win_clear     (win_clear),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_blue      (out_blue),
    .out_green     (out_green),
    .out_red       (out_red),
    .out_frame_end (out_frame_end)
  );

  `BB_ASSERT_IMP(a_queue_no_overflow, q_push, !q_full, "column pushed into a full queue")
  `BB_ASSERT_IMP(a_queue_no_underflow, q_pop, q_valid, "column popped from an empty queue")
  `BB_ASSERT_NEXT(a_queue_full_holds, q_full && !q_pop, q_full, "full queue lost an entry")
  `BB_ASSERT(a_full_stalls_input, !(q_full && q_push), "front end fired into a full queue")

endmodule

[dv/blur_tb_pkg.sv]
// ---------------------------------------------------------------------------
// Box blur testbench package
// Item codes, the blurred pixel record and frame size rules shared by the
// stimulus and the checker.
// ---------------------------------------------------------------------------
package blur_tb_pkg;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_DRAIN = 1'b1
  } blur_action_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_end;
  } blur_px_t;

  // A size register of zero means one; values above the limit saturate.
  function automatic int unsigned frame_extent(input int unsigned reg_value,
                                               input int unsigned limit);
    if (reg_value < 1) return 1;
    if (reg_value > limit) return limit;
    return reg_value;
  endfunction

endpackage

[dv/box_blur_3x3_rgb_checker.sv]
// ---------------------------------------------------------------------------
// Box blur result checker
// Follows register writes and accepted items, keeps its own line store and
// window, predicts every blurred pixel and compares each accepted result.
// ---------------------------------------------------------------------------
module box_blur_3x3_rgb_checker
  import bb_pkg::*, blur_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_action,
  input  logic [CH_W-1:0]       in_blue,
  input  logic [CH_W-1:0]       in_green,
  input  logic [CH_W-1:0]       in_red,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [CH_W-1:0]       out_blue,
  input  logic [CH_W-1:0]       out_green,
  input  logic [CH_W-1:0]       out_red,
  input  logic                  out_frame_end,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    failures,
  output int                    results_due,
  output int                    results_checked
);

  logic [PIX_W-1:0]        upper_line [MAX_WIDTH];
  logic [PIX_W-1:0]        middle_line [MAX_WIDTH];
  logic [PIX_W-1:0]        win [3][3];
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  int unsigned             col_in, row_in, col_out, row_out;
  blur_px_t                blurred_due [$];
  int                      n_fail;
  int                      n_checked;

  function automatic void restart_frame();
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    col_in  = 0;
    row_in  = 0;
    col_out = 0;
    row_out = 0;
  endfunction

  // Mean of the in-frame neighbours of (row_out, col_out). Neighbour dx sits
  // in window column dx+1+shift; a shift of one is used at a row wrap, when
  // the window still holds the end of the previous row.
  function automatic blur_px_t blur_at(input int unsigned w, input int unsigned h,
                                       input int shift);
    int unsigned    acc [3];
    int unsigned    cnt;
    int             rr, cc, wc;
    logic [PIX_W-1:0] px;
    blur_px_t       res;
    acc[0] = 0;
    acc[1] = 0;
    acc[2] = 0;
    cnt = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      rr = int'(row_out) + dy;
      if (rr < 0 || rr >= int'(h)) continue;
      for (int dx = -1; dx <= 1; dx++) begin
        cc = int'(col_out) + dx;
        wc = dx + 1 + shift;
        if (cc < 0 || cc >= int'(w) || wc > 2) continue;
        px = win[dy + 1][wc];
        for (int ch = 0; ch < 3; ch++) acc[ch] += px[8 * ch +: 8];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    res.blue      = 8'((2 * acc[0] + cnt) / (2 * cnt));
    res.green     = 8'((2 * acc[1] + cnt) / (2 * cnt));
    res.red       = 8'((2 * acc[2] + cnt) / (2 * cnt));
    res.frame_end = 1'b0;
    return res;
  endfunction

  function automatic void advance_blur(input logic act, input logic [7:0] b,
                                       input logic [7:0] g, input logic [7:0] r);
    int unsigned      w, h, c, rw;
    logic [PIX_W-1:0] px;
    bit               emit, wrap;
    blur_px_t         res;
    w  = frame_extent(width_reg, MAX_WIDTH);
    h  = frame_extent(height_reg, MAX_HEIGHT);
    c  = col_in;
    rw = row_in;
    // Early drain items and pixels during the flush leave no trace.
    if (act == ACT_PIXEL && rw >= h) return;
    if (act == ACT_DRAIN && rw < h) return;
    px   = (act == ACT_DRAIN) ? '0 : {r, g, b};
    emit = (rw >= 2) || (rw == 1 && c >= 1);
    wrap = (c == 0);
    res  = '0;
    if (emit && wrap) res = blur_at(w, h, 1);
    if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = upper_line[c];
    win[1][2] = middle_line[c];
    win[2][2] = px;
    upper_line[c]  = middle_line[c];
    middle_line[c] = px;
    if (emit && !wrap) res = blur_at(w, h, 0);
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (!emit) return;
    res.frame_end = (row_out == h - 1 && col_out == w - 1);
    blurred_due.push_back(res);
    if (res.frame_end) begin
      restart_frame();
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
  endfunction

  always @(posedge clk) begin
    blur_px_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      restart_frame();
      blurred_due.delete();
      n_fail    = 0;
      n_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (blurred_due.size() == 0) begin
          $error("Result with nothing expected: blue %0d green %0d red %0d frame_end %0b",
                 out_blue, out_green, out_red, out_frame_end);
          n_fail++;
        end else begin
          want = blurred_due.pop_front();
          n_checked++;
          if (out_blue !== want.blue) begin
            $error("out_blue: expected %0d, actual %0d", want.blue, out_blue);
            n_fail++;
          end
          if (out_green !== want.green) begin
            $error("out_green: expected %0d, actual %0d", want.green, out_green);
            n_fail++;
          end
          if (out_red !== want.red) begin
            $error("out_red: expected %0d, actual %0d", want.red, out_red);
            n_fail++;
          end
          if (out_frame_end !== want.frame_end) begin
            $error("out_frame_end: expected %0b, actual %0b", want.frame_end, out_frame_end);
            n_fail++;
          end
        end
      end
      // Any register write throws away the frame in progress.
      if (cfg_we) begin
        if (cfg_index == CFG_IMAGE_WIDTH) begin
          width_reg = cfg_wdata[WIDTH_REG_W-1:0];
          restart_frame();
        end else if (cfg_index == CFG_IMAGE_HEIGHT) begin
          height_reg = cfg_wdata[HEIGHT_REG_W-1:0];
          restart_frame();
        end
      end
      if (in_valid && !in_stall) advance_blur(in_action, in_blue, in_green, in_red);
    end
    failures        <= n_fail;
    results_due     <= blurred_due.size();
    results_checked <= n_checked;
  end

endmodule

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// Box blur 3x3 RGB testbench
// Streams frames of many sizes through the core, with random gaps on the
// input and random stalls on the output, and lets the checker compare every
// blurred pixel against its own prediction.
// ---------------------------------------------------------------------------
module testbench;
  import bb_pkg::*;
  import blur_tb_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 550;
  localparam int WIDE_EXTRA    = 64;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_action;
  logic [CH_W-1:0]       in_blue, in_green, in_red;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CH_W-1:0]       out_blue, out_green, out_red;
  logic                  out_frame_end;
  logic                  cfg_we;
  logic [0:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int                    failures, results_due, results_checked;
  bit                    calm;
  int unsigned           cur_w, cur_h;
  int unsigned           total_items, tally, frames, cut_frames;

  always #5 clk = ~clk;

  box_blur_3x3_rgb_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_blue      (in_blue),
    .in_green     (in_green),
    .in_red       (in_red),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_blue     (out_blue),
    .out_green    (out_green),
    .out_red      (out_red),
    .out_frame_end(out_frame_end),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  box_blur_3x3_rgb_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_blue        (in_blue),
    .in_green       (in_green),
    .in_red         (in_red),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_blue       (out_blue),
    .out_green      (out_green),
    .out_red        (out_red),
    .out_frame_end  (out_frame_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .failures       (failures),
    .results_due    (results_due),
    .results_checked(results_checked)
  );

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(0, 99) < 24);
  end

  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one item and returns at the edge where it is taken.
  task automatic push_item(input blur_action_e act, input logic [7:0] b,
                           input logic [7:0] g, input logic [7:0] r);
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_blue   <= b;
    in_green  <= g;
    in_red    <= r;
    do @(posedge clk); while (in_stall);
    total_items++;
  endtask

  task automatic push_random(input blur_action_e act);
    push_item(act, rand_level(), rand_level(), rand_level());
  endtask

  // Holds the input back until every predicted pixel has come out.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_width(input logic [WIDTH_REG_W-1:0] v);
    logic [CFG_DATA_W-WIDTH_REG_W-1:0] spare;
    spare = $urandom_range(0, 3);
    write_reg(CFG_IMAGE_WIDTH, {spare, v});
    cur_w = frame_extent(v, MAX_WIDTH);
  endtask

  task automatic set_height(input logic [HEIGHT_REG_W-1:0] v);
    write_reg(CFG_IMAGE_HEIGHT, v);
    cur_h = frame_extent(v, MAX_HEIGHT);
  endtask

  // Sends the first 'stop' items of a well-formed frame, salted now and then
  // with drain items that come too early and pixels that arrive mid-flush.
  task automatic run_frame(input int unsigned stop, input bit counted);
    int unsigned npix, span;
    npix = cur_w * cur_h;
    span = npix + cur_w + 1;
    for (int unsigned k = 0; k < span && k < stop; k++) begin
      if (k < npix) begin
        if ($urandom_range(0, 29) == 0) push_random(ACT_DRAIN);
        push_random(ACT_PIXEL);
      end else begin
        if (k < span - 1 && $urandom_range(0, 29) == 0) push_random(ACT_PIXEL);
        push_random(ACT_DRAIN);
      end
      if ($urandom_range(0, 199) == 0) settle();
      if (counted) tally++;
    end
    frames++;
  endtask

  initial begin
    #3_000_000;
    $display("Timeout: the core stopped taking items or delivering results");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned full_len, stop;
    bit          need_write, cut, new_w, new_h;
    int unsigned frame_no;
    logic [WIDTH_REG_W-1:0]  wv;
    logic [HEIGHT_REG_W-1:0] hv;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_action = ACT_PIXEL;
    in_blue   = '0;
    in_green  = '0;
    in_red    = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_wdata = '0;
    calm      = 1'b0;
    total_items = 0;
    tally       = 0;
    frames      = 0;
    cut_frames  = 0;
    cur_w = frame_extent(WIDTH_RESET, MAX_WIDTH);
    cur_h = frame_extent(HEIGHT_RESET, MAX_HEIGHT);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A 3x2 frame of extreme colours, an early drain and a mid-flush pixel.
    set_width(11'd3);
    set_height(13'd2);
    push_item(ACT_DRAIN, 8'hff, 8'hff, 8'hff);
    push_item(ACT_PIXEL, 8'hff, 8'hff, 8'hff);
    push_item(ACT_PIXEL, 8'h00, 8'h00, 8'h00);
    push_item(ACT_PIXEL, 8'hff, 8'h00, 8'hff);
    push_item(ACT_PIXEL, 8'h00, 8'hff, 8'h00);
    push_item(ACT_PIXEL, 8'hff, 8'hff, 8'hff);
    push_item(ACT_PIXEL, 8'h01, 8'h80, 8'hfe);
    push_item(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
    push_item(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
    push_item(ACT_PIXEL, 8'hff, 8'hff, 8'hff);
    push_item(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
    push_item(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
    settle();
    // Zero sizes behave as a single pixel.
    set_width(11'd0);
    set_height(13'd0);
    push_item(ACT_PIXEL, 8'd200, 8'd100, 8'd50);
    push_item(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
    push_item(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
    settle();
    // A frame cut short; the next register write abandons it.
    set_width(11'd2);
    set_height(13'd3);
    push_item(ACT_PIXEL, 8'hff, 8'h00, 8'h00);
    push_item(ACT_PIXEL, 8'h00, 8'hff, 8'h00);
    push_item(ACT_PIXEL, 8'h00, 8'h00, 8'hff);
    push_item(ACT_PIXEL, 8'h80, 8'h80, 8'h80);
    settle();
    cut_frames++;

    need_write = 1'b1;
    frame_no   = 0;
    while (tally < RANDOM_ITEMS) begin
      calm = (frame_no >= 3 && frame_no < 8);
      if (frame_no == 2) begin
        // Widest frame, with width saturation; the first row and the start
        // of the second are sent before it is abandoned.
        settle();
        set_width(11'd2047);
        set_height(13'd2);
        run_frame(cur_w + WIDE_EXTRA, 1'b0);
        cut_frames++;
        need_write = 1'b1;
      end else if (frame_no == 5) begin
        // Tallest frame; only its top is sent before it is abandoned.
        settle();
        set_width(11'd1);
        set_height(13'd8191);
        run_frame($urandom_range(20, 60), 1'b0);
        cut_frames++;
        need_write = 1'b1;
      end else begin
        new_w = need_write || ($urandom_range(0, 1) == 1);
        new_h = need_write || ($urandom_range(0, 1) == 1);
        if (new_w || new_h) settle();
        if (new_w) begin
          case ($urandom_range(0, 9))
            0: wv = 11'd0;
            1: wv = 11'd1;
            2: wv = 11'd2;
            3: wv = 11'($urandom_range(17, 40));
            default: wv = 11'($urandom_range(3, 16));
          endcase
          set_width(wv);
        end
        if (new_h) begin
          case ($urandom_range(0, 9))
            0: hv = 13'd0;
            1: hv = 13'd1;
            2: hv = 13'd2;
            3: hv = 13'($urandom_range(9, 16));
            default: hv = 13'($urandom_range(3, 8));
          endcase
          set_height(hv);
        end
        full_len = cur_w * cur_h + cur_w + 1;
        cut  = ($urandom_range(0, 9) == 0);
        stop = cut ? $urandom_range(1, full_len - 1) : full_len;
        run_frame(stop, 1'b1);
        if (cut) cut_frames++;
        need_write = cut;
      end
      frame_no++;
    end
    calm = 1'b0;

    settle();
    $display("Sent %0d items over %0d frames (%0d abandoned part-way); %0d blurred pixels",
             total_items, frames, cut_frames, results_checked);
    $display("were compared, with frame widths from 1 to 1024 and heights from 1 to 4096.");
    if (results_due != 0) $error("%0d predicted pixels never came out", results_due);
    if (failures == 0 && results_due == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
